>>> hw/rtl/ncks_pkg.sv
// Shared types and constants for the nearest-centroid top-k selector.
// Field widths, the sorted-list entry, the insert request and config codes.
// No dependencies.
`default_nettype none

package ncks_pkg;

  localparam int ELEM_W     = 16;
  localparam int DIM_W      = 7;
  localparam int CELL_W     = 15;
  localparam int DIST_W     = 48;
  localparam int SQ_W       = 32;
  localparam int RANK_W     = 5;
  localparam int PROBES_W   = 6;
  localparam int DIMS_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [PROBES_W-1:0] PROBES_RESET = 6'd32;
  localparam logic [DIMS_W-1:0]   DIMS_RESET   = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROBES_IN_USE = 2'd0,
    CFG_DIMS_IN_USE   = 2'd1
  } cfg_reg_t;

  // One slot of the sorted list: distance and cell identifier.
  typedef struct packed {
    logic [DIST_W-1:0] sq_dist;
    logic [CELL_W-1:0] cell_id;
  } entry_t;

  // Finished centroid heading for the list.
  typedef struct packed {
    logic   valid;
    logic   fin;
    entry_t ent;
  } ins_t;

  // Per-slot position flags derived from fill count and probe limit.
  typedef struct packed {
    logic beyond_fill;
    logic within_limit;
  } slot_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/ncks_cell.sv
// One slot of the sorted top-k list: compare against the incoming pair and
// either hold, take the left neighbor's entry, or take the new pair.
// Depends on ncks_pkg.
`default_nettype none

module ncks_cell import ncks_pkg::*; (
  input  logic      clk,
  input  logic      ins_en,
  input  entry_t    new_ent,
  input  entry_t    left_ent,
  input  logic      left_gt,
  input  slot_ctl_t ctl,
  output entry_t    ent_r,
  output entry_t    ent_nxt,
  output logic      gt
);

  logic upd;

  // Ties keep the older entry ahead: only a strictly larger distance yields.
  assign gt  = ctl.beyond_fill || (ent_r.sq_dist > new_ent.sq_dist);
  assign upd = ins_en && gt && ctl.within_limit;

  always_comb begin
    ent_nxt = ent_r;
    if (upd) begin
      ent_nxt = left_gt ? left_ent : new_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/ncks_dist.sv
// Distance datapath: query store, difference and square, saturating
// accumulate; emits one insert request per finished centroid.
// Depends on ncks_pkg.
`default_nettype none

module ncks_dist import ncks_pkg::*; #(
  parameter int DIMENSIONS = 128,
  parameter int DIM_AW     = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              take,
  input  logic              mode,
  input  logic [DIM_W-1:0]  dim_index,
  input  logic [ELEM_W-1:0] element_value,
  input  logic [CELL_W-1:0] cell_index,
  input  logic              final_cell,
  input  logic [DIM_AW-1:0] last_dim,
  output ins_t              ins
);

  logic [ELEM_W-1:0] query_mem [DIMENSIONS];

  logic [31:0]       dim_wide;
  logic              dim_ok;
  logic [DIM_AW-1:0] addr;

  logic              s1_v_r, s1_end_r, s1_fin_r;
  logic [CELL_W-1:0] s1_cell_r;
  logic [ELEM_W-1:0] s1_val_r, s1_q_r;

  logic              s2_v_r, s2_end_r, s2_fin_r;
  logic [CELL_W-1:0] s2_cell_r;
  logic [SQ_W-1:0]   s2_sq_r;

  logic [DIST_W-1:0] acc_r;
  logic              ins_v_r;
  logic              ins_fin_r;
  entry_t            ins_ent_r;

  logic [ELEM_W:0]   diff, mag;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] sat;

  assign dim_wide = {{(32 - DIM_W){1'b0}}, dim_index};
  assign dim_ok   = dim_wide < 32'(DIMENSIONS);
  assign addr     = dim_wide[DIM_AW-1:0];

  always_ff @(posedge clk) begin
    if (take && !mode && dim_ok) begin
      query_mem[addr] <= element_value;
    end
    if (take && mode) begin
      s1_q_r <= query_mem[addr];
    end
  end

  assign diff = {s1_q_r[ELEM_W-1], s1_q_r} - {s1_val_r[ELEM_W-1], s1_val_r};
  assign mag  = diff[ELEM_W] ? (~diff + 1'b1) : diff;

  assign sum = {1'b0, acc_r} + {{(DIST_W + 1 - SQ_W){1'b0}}, s2_sq_r};
  assign sat = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      ins_v_r <= 1'b0;
      acc_r   <= '0;
    end else if (adv) begin
      s1_v_r  <= take && mode && dim_ok;
      s2_v_r  <= s1_v_r;
      ins_v_r <= s2_v_r && s2_end_r;
      if (s2_v_r) begin
        acc_r <= s2_end_r ? '0 : sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_end_r  <= addr == last_dim;
      s1_fin_r  <= final_cell;
      s1_cell_r <= cell_index;
      s1_val_r  <= element_value;

      s2_end_r  <= s1_end_r;
      s2_fin_r  <= s1_fin_r;
      s2_cell_r <= s1_cell_r;
      s2_sq_r   <= mag[ELEM_W-1:0] * mag[ELEM_W-1:0];

      ins_fin_r         <= s2_fin_r;
      ins_ent_r.sq_dist <= sat;
      ins_ent_r.cell_id <= s2_cell_r;
    end
  end

  assign ins.valid = ins_v_r;
  assign ins.fin   = ins_fin_r;
  assign ins.ent   = ins_ent_r;

endmodule

`default_nettype wire

>>> hw/rtl/nearest_centroid_top_k_select_unit.sv
// Path: a centroid's ending beat passes the s1, s2 and insert registers before it
// reaches the sorted list; its release on out_* starts once the drain row is loaded.
// Throughput: one input beat per cycle; results leave one per cycle while out_ready
// is high. Input stalls only while a finished list waits for the drain row to empty.
// Reset: registers return to 32 probes and 128 dimensions, the list and the
// drain empty; the query store keeps its contents and is not cleared.
`default_nettype none

module nearest_centroid_top_k_select_unit import ncks_pkg::*; #(
  parameter int DIMENSIONS = 128,
  parameter int MAX_PROBES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [DIM_W-1:0]      in_dim_index,
  input  logic [ELEM_W-1:0]     in_element_value,
  input  logic [CELL_W-1:0]     in_cell_index,
  input  logic                  in_final_cell,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CELL_W-1:0]     out_cell_id,
  output logic [DIST_W-1:0]     out_sq_distance,
  output logic [RANK_W-1:0]     out_rank,
  output logic                  out_last_of_run,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIM_AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_PROBES + 1);

  // Configuration registers.
  logic [PROBES_W-1:0] probes_r;
  logic [DIMS_W-1:0]   dims_r;

  // Control.
  logic        adv, take, stall, snap, out_take;
  ins_t        ins;

  // Derived limits.
  logic [31:0]       k_wide, d_wide, d_last;
  logic [CNT_W-1:0]  k_eff, n_eff, filled_r, filled_nxt, n_out;
  logic [DIM_AW-1:0] last_dim;

  // List row.
  entry_t                cell_q   [MAX_PROBES];
  entry_t                cell_nxt [MAX_PROBES];
  logic [MAX_PROBES-1:0] gt_vec, within_vec;
  logic                  inserted;

  // Drain row.
  entry_t           drain_r [MAX_PROBES];
  logic [CNT_W-1:0] remain_r;
  logic [CNT_W-1:0] rank_r;
  logic [31:0]      rank_wide;

  // Writes are taken at once; software must write only while the block is idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probes_r <= PROBES_RESET;
      dims_r   <= DIMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PROBES_IN_USE: probes_r <= cfg_data[PROBES_W-1:0];
        CFG_DIMS_IN_USE:   dims_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the probe count to 1..MAX_PROBES and the dimension count to
  // 1..DIMENSIONS.
  always_comb begin
    k_wide = 32'(probes_r);
    if (k_wide == 32'd0) begin
      k_wide = 32'd1;
    end else if (k_wide > 32'(MAX_PROBES)) begin
      k_wide = 32'(MAX_PROBES);
    end
    d_wide = 32'(dims_r);
    if (d_wide == 32'd0) begin
      d_wide = 32'd1;
    end else if (d_wide > 32'(DIMENSIONS)) begin
      d_wide = 32'(DIMENSIONS);
    end
    d_last = d_wide - 32'd1;
  end

  assign k_eff    = k_wide[CNT_W-1:0];
  assign last_dim = d_last[DIM_AW-1:0];
  assign n_eff    = (filled_r < k_eff) ? filled_r : k_eff;

  // Hold the whole pipe when a finished list meets a busy drain row.
  assign stall    = ins.valid && ins.fin && (remain_r != '0);
  assign adv      = !stall;
  assign in_ready = adv;
  assign take     = in_valid && in_ready;

  ncks_dist #(
    .DIMENSIONS (DIMENSIONS),
    .DIM_AW     (DIM_AW)
  ) u_dist (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .take          (take),
    .mode          (in_mode),
    .dim_index     (in_dim_index),
    .element_value (in_element_value),
    .cell_index    (in_cell_index),
    .final_cell    (in_final_cell),
    .last_dim      (last_dim),
    .ins           (ins)
  );

  // Row of compare-and-shift cells; each slot looks only at its left
  // neighbor, so the insert position falls out of the gt chain.
  for (genvar g = 0; g < MAX_PROBES; g++) begin : g_cell
    slot_ctl_t ctl;
    entry_t    left_ent;
    logic      left_gt;

    assign ctl.beyond_fill  = CNT_W'(g) >= n_eff;
    assign ctl.within_limit = (CNT_W'(g) < k_eff) && (CNT_W'(g) <= n_eff);
    assign within_vec[g]    = ctl.within_limit;

    if (g == 0) begin : g_head
      assign left_ent = ins.ent;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_ent = cell_q[g-1];
      assign left_gt  = gt_vec[g-1];
    end

    ncks_cell u_cell (
      .clk      (clk),
      .ins_en   (ins.valid && adv),
      .new_ent  (ins.ent),
      .left_ent (left_ent),
      .left_gt  (left_gt),
      .ctl      (ctl),
      .ent_r    (cell_q[g]),
      .ent_nxt  (cell_nxt[g]),
      .gt       (gt_vec[g])
    );
  end

  // A pair lands if some slot inside the probe limit yields to it.
  assign inserted = |(gt_vec & within_vec);

  always_comb begin
    filled_nxt = filled_r;
    if (ins.valid && inserted) begin
      filled_nxt = (n_eff < k_eff) ? n_eff + 1'b1 : k_eff;
    end
  end

  assign n_out    = (filled_nxt < k_eff) ? filled_nxt : k_eff;
  assign snap     = ins.valid && ins.fin && adv;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
    end else if (ins.valid && adv) begin
      // Drop the list once it is copied out for release.
      filled_r <= ins.fin ? '0 : filled_nxt;
    end
  end

  // Drain row: copy the finished list, then advance one slot per beat.
  always_ff @(posedge clk) begin
    if (snap) begin
      for (int i = 0; i < MAX_PROBES; i++) begin
        drain_r[i] <= cell_nxt[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < MAX_PROBES - 1; i++) begin
        drain_r[i] <= drain_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= '0;
      rank_r   <= '0;
    end else if (snap) begin
      remain_r <= n_out;
      rank_r   <= '0;
    end else if (out_take) begin
      remain_r <= remain_r - 1'b1;
      rank_r   <= out_last_of_run ? '0 : rank_r + 1'b1;
    end
  end

  assign rank_wide       = 32'(rank_r);
  assign out_valid       = remain_r != '0;
  assign out_cell_id     = drain_r[0].cell_id;
  assign out_sq_distance = drain_r[0].sq_dist;
  assign out_rank        = rank_wide[RANK_W-1:0];
  assign out_last_of_run = remain_r == CNT_W'(1);

  // A release always carries at least one result.
  a_snap_loads : assert property (@(posedge clk) disable iff (!rst_n)
    snap |=> remain_r != '0)
    else $error("release left the drain row empty");

  // After the final beat of a run the next run starts at rank zero.
  a_rank_restart : assert property (@(posedge clk) disable iff (!rst_n)
    out_take && out_last_of_run |=> rank_r == '0)
    else $error("rank did not restart after end of run");

  // The fill and drain counts never pass the list depth.
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(MAX_PROBES) && remain_r <= CNT_W'(MAX_PROBES))
    else $error("fill or drain count beyond list depth");

endmodule

`default_nettype wire
